// ===== hdl/iedf_pkg.sv =====
// ----------------------------------------------------------------------------
// iedf_pkg
// Register indexes, reset values and fixed-point constants for the interval
// EMA distance filter.
// ----------------------------------------------------------------------------
package iedf_pkg;

    localparam int DistW  = 16;
    localparam int AlphaW = 9;
    localparam int IdxW   = 2;
    localparam int CfgW   = 16;
    localparam int AccW   = DistW + AlphaW;

    localparam logic [IdxW-1:0] REG_INTERVAL  = 2'd0;
    localparam logic [IdxW-1:0] REG_ALPHA     = 2'd1;
    localparam logic [IdxW-1:0] REG_THRESHOLD = 2'd2;
    localparam logic [IdxW-1:0] REG_ENABLE    = 2'd3;

    localparam logic [DistW-1:0]  INTERVAL_RST  = 16'd100;
    localparam logic [AlphaW-1:0] ALPHA_RST     = 9'd77;
    localparam logic [DistW-1:0]  THRESHOLD_RST = 16'd16;

    localparam logic [AlphaW-1:0] ALPHA_ONE = 9'd256;
    localparam logic [DistW-1:0]  DIST_MAX  = 16'hFFFF;

    typedef struct packed {
        logic             cmd;
        logic [DistW-1:0] raw;
    } in_word_t;

endpackage

// ===== hdl/interval_ema_distance_filter.sv =====
// ----------------------------------------------------------------------------
// interval_ema_distance_filter
// Tick-driven exponential moving average of a distance with change detection.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per tick (s_tuser = 0) or manual measurement
//   (s_tuser = 1), s_tdata carries the raw distance in Q12.4 cm.
//   Master stream: one word per input word; m_tdata is the filtered distance,
//   m_tuser flags whether a sample was taken and whether a change was raised.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write interval (0), alpha (1),
//   threshold (2) and enable (3); write only while the block is idle.
//   Pipeline: an accepted word passes the input register, then the result
//   register. Throughput: one word per cycle while m_tready stays high; the
//   filter state updates as a word moves from the input register to the
//   result register, so the next word sees it without a gap.
//   Reset: clears both stages, the filtered, reported and elapsed state, and
//   loads the register defaults.
//   Stall: when m_tready is low the result holds; the input register still
//   fills once, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module interval_ema_distance_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [iedf_pkg::DistW-1:0]  s_tdata,   // [15:0] raw_distance
    input  logic                        s_tuser,   // [0] cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [iedf_pkg::DistW-1:0]  m_tdata,   // [15:0] filtered_distance
    output logic [1:0]                  m_tuser,   // [0] measured, [1] changed
    input  logic                        cfg_wr_en,
    input  logic [iedf_pkg::IdxW-1:0]   cfg_index,
    input  logic [iedf_pkg::CfgW-1:0]   cfg_wdata
);

    logic [iedf_pkg::DistW-1:0]  interval_reg;
    logic [iedf_pkg::AlphaW-1:0] alpha_reg;
    logic [iedf_pkg::DistW-1:0]  threshold_reg;
    logic                        enable_reg;

    logic                        in_valid_reg;
    iedf_pkg::in_word_t          in_word_reg;

    logic [iedf_pkg::DistW-1:0]  filtered_reg, filtered_next;
    logic [iedf_pkg::DistW-1:0]  reported_reg, reported_next;
    logic [iedf_pkg::DistW-1:0]  elapsed_reg, elapsed_next;

    logic                        out_valid_reg;
    logic [iedf_pkg::DistW-1:0]  out_dist_reg;
    logic                        out_measured_reg, out_measured_next;
    logic                        out_changed_reg, out_changed_next;

    logic                        advance;
    logic [iedf_pkg::DistW-1:0]  elapsed_sat;
    logic                        timed_hit;
    logic                        sample;
    logic [iedf_pkg::AlphaW-1:0] alpha_eff;
    logic [iedf_pkg::AlphaW-1:0] alpha_inv;
    logic [iedf_pkg::AccW-1:0]   acc;
    logic [iedf_pkg::DistW-1:0]  sampled;
    logic [iedf_pkg::DistW-1:0]  diff;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign alpha_eff = alpha_reg[iedf_pkg::AlphaW-1] ? iedf_pkg::ALPHA_ONE : alpha_reg;
    assign alpha_inv = iedf_pkg::ALPHA_ONE - alpha_eff;
    assign acc = iedf_pkg::AccW'(alpha_eff) * iedf_pkg::AccW'(in_word_reg.raw)
               + iedf_pkg::AccW'(alpha_inv) * iedf_pkg::AccW'(filtered_reg);
    assign sampled = (filtered_reg == '0) ? in_word_reg.raw
                                          : acc[iedf_pkg::DistW+7:8];

    assign elapsed_sat = (elapsed_reg != iedf_pkg::DIST_MAX)
                       ? elapsed_reg + iedf_pkg::DistW'(1)
                       : elapsed_reg;
    assign timed_hit = !in_word_reg.cmd && enable_reg && (elapsed_sat >= interval_reg);
    assign sample    = in_word_reg.cmd || timed_hit;
    assign diff = (sampled >= reported_reg) ? sampled - reported_reg
                                            : reported_reg - sampled;

    always_comb begin
        filtered_next     = filtered_reg;
        reported_next     = reported_reg;
        elapsed_next      = elapsed_reg;
        out_measured_next = sample;
        out_changed_next  = 1'b0;
        if (sample) begin
            filtered_next = sampled;
        end
        if (!in_word_reg.cmd && enable_reg) begin
            elapsed_next = timed_hit ? '0 : elapsed_sat;
        end
        if (timed_hit && (diff >= threshold_reg)) begin
            out_changed_next = 1'b1;
            reported_next    = sampled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= iedf_pkg::INTERVAL_RST;
            alpha_reg     <= iedf_pkg::ALPHA_RST;
            threshold_reg <= iedf_pkg::THRESHOLD_RST;
            enable_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iedf_pkg::REG_INTERVAL:  interval_reg  <= cfg_wdata;
                iedf_pkg::REG_ALPHA:     alpha_reg     <= cfg_wdata[iedf_pkg::AlphaW-1:0];
                iedf_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata;
                iedf_pkg::REG_ENABLE:    enable_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            reported_reg  <= '0;
            elapsed_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                filtered_reg  <= filtered_next;
                reported_reg  <= reported_next;
                elapsed_reg   <= elapsed_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg.cmd <= s_tuser;
            in_word_reg.raw <= s_tdata;
        end
        if (advance) begin
            out_dist_reg     <= filtered_next;
            out_measured_reg <= out_measured_next;
            out_changed_reg  <= out_changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = {out_changed_reg, out_measured_reg};

endmodule
